// ===== sv/fdr_pkg.sv =====
// Shared types and constants for the Fresnel dielectric reflectance pipeline.
// Used by every module of the block; depends on nothing.
`default_nettype none

package fdr_pkg;

	// Fixed-point unity values and the rounding half
	localparam logic signed [15:0] ONE_Q14     = 16'sd16384;
	localparam logic [15:0]        ONE_Q15     = 16'd32768;
	localparam logic [30:0]        RATIO_ONE   = 31'h4000_0000;
	localparam logic [62:0]        ROUND_HALF  = 63'h0000_2000_0000_0000;

	// Configuration register indexes
	localparam int unsigned        CFG_IDX_W   = 8;
	localparam logic [CFG_IDX_W-1:0] REG_INDEX_INCIDENT    = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INDEX_TRANSMITTED = 8'd1;

	// Register reset values, Q3.12
	localparam logic [14:0]        INDEX_INC_RST = 15'd4096;
	localparam logic [14:0]        INDEX_TRN_RST = 15'd6144;

	// Pipeline step counts
	localparam int unsigned        CDIV_STEPS  = 29;
	localparam int unsigned        SQRT_STEPS  = 15;
	localparam int unsigned        RDIV_STEPS  = 31;

	// Side data carried with an item down the pipeline
	typedef struct packed {
		logic [14:0] ci;
		logic [14:0] ei;
		logic [14:0] et;
		logic        tir;
	} fdr_side_t;

endpackage

`default_nettype wire

// ===== sv/fdr_front.sv =====
// Front end: clamp, index swap, squares and the total internal reflection test.
// Four register stages; depends on fdr_pkg.
`default_nettype none

module fdr_front import fdr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_v,
	input  logic signed [15:0] cos_in,
	input  logic [14:0]       ei_cfg,
	input  logic [14:0]       et_cfg,
	output logic              out_v,
	output logic [57:0]       dvd,
	output logic [29:0]       dvs,
	output fdr_side_t         out_side
);

	logic signed [15:0] c_cl;
	logic [14:0] ci, eiz, etz, ei_sw, et_sw;
	logic        pos;

	logic        v_s1, v_s2, v_s3, v_s4;
	logic [14:0] ci_s1, ei_s1, et_s1;
	logic [29:0] ci2_s1, ei2_s1, et2_s1;
	logic [14:0] ci_s2, ei_s2, et_s2;
	logic [29:0] et2_s2;
	logic [44:0] plo_s2;
	logic [43:0] phi_s2;
	logic [14:0] ci_s3, ei_s3, et_s3;
	logic [29:0] et2_s3;
	logic [58:0] lhs_s3;
	logic [57:0] d_s4;
	logic [29:0] et2_s4;
	fdr_side_t   side_s4;
	logic [28:0] sin2i;
	logic [58:0] diff;

	// Clamp the cosine and swap indices when not entering
	always_comb begin
		if (cos_in > ONE_Q14) begin
			c_cl = ONE_Q14;
		end else if (cos_in < -ONE_Q14) begin
			c_cl = -ONE_Q14;
		end else begin
			c_cl = cos_in;
		end
		ci    = c_cl[15] ? 15'(-c_cl) : c_cl[14:0];
		pos   = !c_cl[15] && (c_cl != 16'sd0);
		eiz   = (ei_cfg == 15'd0) ? 15'd1 : ei_cfg;
		etz   = (et_cfg == 15'd0) ? 15'd1 : et_cfg;
		ei_sw = pos ? eiz : etz;
		et_sw = pos ? etz : eiz;
	end

	// Stage 2 inputs: sine squared
	assign sin2i = 29'(30'h1000_0000 - ci2_s1);

	// Stage 4 inputs: compare and difference
	assign diff = {1'b0, et2_s3, 28'd0} - lhs_s3;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (adv) begin
			ci_s1  <= ci;
			ei_s1  <= ei_sw;
			et_s1  <= et_sw;
			ci2_s1 <= {15'd0, ci} * {15'd0, ci};
			ei2_s1 <= {15'd0, ei_sw} * {15'd0, ei_sw};
			et2_s1 <= {15'd0, et_sw} * {15'd0, et_sw};

			ci_s2  <= ci_s1;
			ei_s2  <= ei_s1;
			et_s2  <= et_s1;
			et2_s2 <= et2_s1;
			plo_s2 <= 45'(ei2_s1) * 45'(sin2i[14:0]);
			phi_s2 <= 44'(ei2_s1) * 44'(sin2i[28:15]);

			ci_s3  <= ci_s2;
			ei_s3  <= ei_s2;
			et_s3  <= et_s2;
			et2_s3 <= et2_s2;
			lhs_s3 <= (59'(phi_s2) << 15) + 59'(plo_s2);

			d_s4         <= diff[57:0];
			et2_s4       <= et2_s3;
			side_s4.ci   <= ci_s3;
			side_s4.ei   <= ei_s3;
			side_s4.et   <= et_s3;
			side_s4.tir  <= diff[58] || (diff == 59'd0);
		end
	end

	assign out_v    = v_s4;
	assign dvd      = d_s4;
	assign dvs      = et2_s4;
	assign out_side = side_s4;

endmodule

`default_nettype wire

// ===== sv/fdr_cdiv.sv =====
// Pipelined restoring divider for the transmitted cosine squared, one bit a stage.
// Depends on fdr_pkg.
`default_nettype none

module fdr_cdiv import fdr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic        in_v,
	input  logic [57:0] dvd,
	input  logic [29:0] dvs,
	input  fdr_side_t   in_side,
	output logic        out_v,
	output logic [28:0] cos2t,
	output fdr_side_t   out_side
);

	logic        v_s    [CDIV_STEPS];
	logic [29:0] rem_s  [CDIV_STEPS];
	logic [28:0] quo_s  [CDIV_STEPS];
	logic [27:0] low_s  [CDIV_STEPS];
	logic [29:0] dvs_s  [CDIV_STEPS];
	fdr_side_t   side_s [CDIV_STEPS];

	for (genvar k = 0; k < CDIV_STEPS; k++) begin : g_step
		logic [30:0] trial;
		logic [28:0] quo_in;
		logic [27:0] low_in;
		logic [29:0] dvs_in;
		fdr_side_t   side_in;
		logic        v_in;
		logic        ge;

		if (k == 0) begin : g_first
			assign trial   = {1'b0, dvd[57:28]};
			assign quo_in  = '0;
			assign low_in  = dvd[27:0];
			assign dvs_in  = dvs;
			assign side_in = in_side;
			assign v_in    = in_v;
		end else begin : g_next
			assign trial   = {rem_s[k-1], low_s[k-1][27]};
			assign quo_in  = quo_s[k-1];
			assign low_in  = {low_s[k-1][26:0], 1'b0};
			assign dvs_in  = dvs_s[k-1];
			assign side_in = side_s[k-1];
			assign v_in    = v_s[k-1];
		end

		assign ge = trial >= {1'b0, dvs_in};

		// Advance valid bit
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (adv) begin
				v_s[k] <= v_in;
			end
		end

		// Subtract when the trial remainder fits
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k]  <= ge ? 30'(trial - {1'b0, dvs_in}) : trial[29:0];
				quo_s[k]  <= {quo_in[27:0], ge};
				low_s[k]  <= low_in;
				dvs_s[k]  <= dvs_in;
				side_s[k] <= side_in;
			end
		end
	end

	assign out_v    = v_s[CDIV_STEPS-1];
	assign cos2t    = quo_s[CDIV_STEPS-1];
	assign out_side = side_s[CDIV_STEPS-1];

endmodule

`default_nettype wire

// ===== sv/fdr_sqrt.sv =====
// Pipelined integer square root of the transmitted cosine squared, one root bit a stage.
// Depends on fdr_pkg.
`default_nettype none

module fdr_sqrt import fdr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic        in_v,
	input  logic [28:0] cos2t,
	input  fdr_side_t   in_side,
	output logic        out_v,
	output logic [14:0] ct,
	output fdr_side_t   out_side
);

	logic        v_s    [SQRT_STEPS];
	logic [28:0] val_s  [SQRT_STEPS];
	logic [29:0] res_s  [SQRT_STEPS];
	fdr_side_t   side_s [SQRT_STEPS];

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		localparam logic [29:0] BitK = 30'd1 << (28 - 2 * k);
		logic [28:0] val_in;
		logic [29:0] res_in;
		fdr_side_t   side_in;
		logic        v_in;
		logic [30:0] sum;
		logic        ge;

		if (k == 0) begin : g_first
			assign val_in  = cos2t;
			assign res_in  = '0;
			assign side_in = in_side;
			assign v_in    = in_v;
		end else begin : g_next
			assign val_in  = val_s[k-1];
			assign res_in  = res_s[k-1];
			assign side_in = side_s[k-1];
			assign v_in    = v_s[k-1];
		end

		assign sum = {1'b0, res_in} + {1'b0, BitK};
		assign ge  = {2'b0, val_in} >= sum;

		// Advance valid bit
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (adv) begin
				v_s[k] <= v_in;
			end
		end

		// Take the trial bit when it fits under the remainder
		always_ff @(posedge clk) begin
			if (adv) begin
				val_s[k]  <= ge ? 29'({2'b0, val_in} - sum) : val_in;
				res_s[k]  <= ge ? ((res_in >> 1) + BitK) : (res_in >> 1);
				side_s[k] <= side_in;
			end
		end
	end

	assign out_v    = v_s[SQRT_STEPS-1];
	assign ct       = res_s[SQRT_STEPS-1][14:0];
	assign out_side = side_s[SQRT_STEPS-1];

endmodule

`default_nettype wire

// ===== sv/fdr_ratio.sv =====
// Amplitude ratios: products, pipelined dividers for both polarizations, squares.
// Depends on fdr_pkg.
`default_nettype none

module fdr_ratio import fdr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic        in_v,
	input  logic [14:0] ct,
	input  fdr_side_t   in_side,
	output logic        out_v,
	output logic [61:0] sq_par,
	output logic [61:0] sq_perp,
	output logic        tir
);

	logic             v_s1, v_s2, v_s3;
	logic [1:0][29:0] x_s1, y_s1;
	logic             tir_s1, tir_s2, tir_s3;
	logic [1:0][29:0] num_s2;
	logic [1:0][30:0] den_s2;
	logic [1:0]       z_s2;
	logic [1:0][61:0] sq_s3;

	logic             dv_s   [RDIV_STEPS];
	logic [1:0][30:0] rem_s  [RDIV_STEPS];
	logic [1:0][30:0] quo_s  [RDIV_STEPS];
	logic [1:0][30:0] den_s  [RDIV_STEPS];
	logic [1:0]       z_s    [RDIV_STEPS];
	logic             tir_s  [RDIV_STEPS];

	logic [1:0][30:0] r_fin;

	// Advance valid bits of the product, difference and square stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= dv_s[RDIV_STEPS-1];
		end
	end

	// Form the four products, then difference and sum per polarization
	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1[0] <= {15'd0, in_side.et} * {15'd0, in_side.ci};
			y_s1[0] <= {15'd0, in_side.ei} * {15'd0, ct};
			x_s1[1] <= {15'd0, in_side.ei} * {15'd0, in_side.ci};
			y_s1[1] <= {15'd0, in_side.et} * {15'd0, ct};
			tir_s1  <= in_side.tir;
			for (int l = 0; l < 2; l++) begin
				num_s2[l] <= (x_s1[l] > y_s1[l]) ? (x_s1[l] - y_s1[l]) : (y_s1[l] - x_s1[l]);
				den_s2[l] <= {1'b0, x_s1[l]} + {1'b0, y_s1[l]};
				z_s2[l]   <= (x_s1[l] == 30'd0) && (y_s1[l] == 30'd0);
			end
			tir_s2 <= tir_s1;
		end
	end

	// Divider stages, one quotient bit each
	for (genvar k = 0; k < RDIV_STEPS; k++) begin : g_step
		logic [1:0][31:0] trial;
		logic [1:0][30:0] quo_in, den_in;
		logic [1:0]       z_in;
		logic             tir_in;
		logic             v_in;
		logic [1:0]       ge;

		if (k == 0) begin : g_first
			assign trial[0] = {2'b0, num_s2[0]};
			assign trial[1] = {2'b0, num_s2[1]};
			assign quo_in   = '0;
			assign den_in   = den_s2;
			assign z_in     = z_s2;
			assign tir_in   = tir_s2;
			assign v_in     = v_s2;
		end else begin : g_next
			assign trial[0] = {rem_s[k-1][0], 1'b0};
			assign trial[1] = {rem_s[k-1][1], 1'b0};
			assign quo_in   = quo_s[k-1];
			assign den_in   = den_s[k-1];
			assign z_in     = z_s[k-1];
			assign tir_in   = tir_s[k-1];
			assign v_in     = dv_s[k-1];
		end

		assign ge[0] = trial[0] >= {1'b0, den_in[0]};
		assign ge[1] = trial[1] >= {1'b0, den_in[1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[k] <= 1'b0;
			end else if (adv) begin
				dv_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int l = 0; l < 2; l++) begin
					rem_s[k][l] <= ge[l] ? 31'(trial[l] - {1'b0, den_in[l]}) : trial[l][30:0];
					quo_s[k][l] <= {quo_in[l][29:0], ge[l]};
				end
				den_s[k] <= den_in;
				z_s[k]   <= z_in;
				tir_s[k] <= tir_in;
			end
		end
	end

	// Zero denominator reads as a ratio of one
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			r_fin[l] = z_s[RDIV_STEPS-1][l] ? RATIO_ONE : quo_s[RDIV_STEPS-1][l];
		end
	end

	// Square each ratio
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < 2; l++) begin
				sq_s3[l] <= {31'd0, r_fin[l]} * {31'd0, r_fin[l]};
			end
			tir_s3 <= tir_s[RDIV_STEPS-1];
		end
	end

	assign out_v   = v_s3;
	assign sq_par  = sq_s3[0];
	assign sq_perp = sq_s3[1];
	assign tir     = tir_s3;

endmodule

`default_nettype wire

// ===== sv/fresnel_dielectric_reflectance.sv =====
// Top level of the Fresnel dielectric reflectance pipeline: configuration
// registers, stall control and the rounding output stage.
// Depends on fdr_pkg, fdr_front, fdr_cdiv, fdr_sqrt and fdr_ratio.
//
// Usage:
//   Input channel in_valid/in_ready carries cos_incident (signed Q1.14).
//   Output channel out_valid/out_ready carries reflectance (Q1.15) and
//   total_internal. Configuration channel cfg_valid/cfg_ready writes
//   index_incident (index 0) and index_transmitted (index 1) from cfg_data;
//   other indexes are dropped. cfg_ready is always high; write only while idle.
//   Throughput is one item per cycle: the chain of 83 register stages
//   (29-step divider for the transmitted cosine, 15-step square root,
//   31-step ratio dividers) moves as one, so a new item enters every cycle
//   the output side is not stalled. When the receiver holds out_ready low
//   with a result waiting, the whole pipeline holds and in_ready drops;
//   nothing is lost or repeated.
//   Reset clears all valid bits and loads the indices with 1.0 and 1.5.
`default_nettype none

module fresnel_dielectric_reflectance import fdr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [15:0]   cos_incident,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [15:0]          reflectance,
	output logic                 total_internal,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [14:0]          cfg_data
);

	logic [14:0] ei_q, et_q;
	logic        adv;
	logic        out_v_q;
	logic [15:0] refl_q;
	logic        tir_q;

	logic        f_v, c_v, s_v, r_v, r_tir;
	logic [57:0] f_dvd;
	logic [29:0] f_dvs;
	fdr_side_t   f_side, c_side, s_side;
	logic [28:0] c_cos2t;
	logic [14:0] s_ct;
	logic [61:0] r_sq_par, r_sq_perp;
	logic [62:0] sum;
	logic [16:0] rnd;

	// Hold the pipeline while a result waits
	assign adv       = !out_v_q || out_ready;
	assign in_ready  = adv;
	assign cfg_ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ei_q <= INDEX_INC_RST;
			et_q <= INDEX_TRN_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_INDEX_INCIDENT:    ei_q <= cfg_data;
				REG_INDEX_TRANSMITTED: et_q <= cfg_data;
				default: ;
			endcase
		end
	end

	fdr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_v     (in_valid),
		.cos_in   (cos_incident),
		.ei_cfg   (ei_q),
		.et_cfg   (et_q),
		.out_v    (f_v),
		.dvd      (f_dvd),
		.dvs      (f_dvs),
		.out_side (f_side)
	);

	fdr_cdiv u_cdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_v     (f_v),
		.dvd      (f_dvd),
		.dvs      (f_dvs),
		.in_side  (f_side),
		.out_v    (c_v),
		.cos2t    (c_cos2t),
		.out_side (c_side)
	);

	fdr_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_v     (c_v),
		.cos2t    (c_cos2t),
		.in_side  (c_side),
		.out_v    (s_v),
		.ct       (s_ct),
		.out_side (s_side)
	);

	fdr_ratio u_ratio (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_v    (s_v),
		.ct      (s_ct),
		.in_side (s_side),
		.out_v   (r_v),
		.sq_par  (r_sq_par),
		.sq_perp (r_sq_perp),
		.tir     (r_tir)
	);

	// Mean of squares, rounded half up to Q1.15
	assign sum = {1'b0, r_sq_par} + {1'b0, r_sq_perp} + ROUND_HALF;
	assign rnd = sum[62:46];

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= r_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tir_q <= r_tir;
			if (r_tir || (rnd > {1'b0, ONE_Q15})) begin
				refl_q <= ONE_Q15;
			end else begin
				refl_q <= rnd[15:0];
			end
		end
	end

	assign out_valid      = out_v_q;
	assign reflectance    = refl_q;
	assign total_internal = tir_q;

endmodule

`default_nettype wire

// ===== sv/fdr_checker.sv =====
// Port-level checks for the Fresnel dielectric reflectance block, with its bind.
// Depends on fdr_pkg and the top level's ports.
`default_nettype none

module fdr_checker import fdr_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] reflectance,
	input logic        total_internal
);

	// A stalled item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(reflectance)
			&& $stable(total_internal))
		else $error("stalled output item changed");

	// Total internal reflection forces unity
	a_tir_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && total_internal |-> reflectance == ONE_Q15)
		else $error("total internal reflection without unity reflectance");

	// Reflectance saturates at one
	a_refl_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> reflectance <= ONE_Q15)
		else $error("reflectance above one");

	// An empty output stage never blocks input
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

endmodule

bind fresnel_dielectric_reflectance fdr_checker u_fdr_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.reflectance    (reflectance),
	.total_internal (total_internal)
);

`default_nettype wire
